[design/qte_pkg.sv]
`timescale 1ns / 1ps
package qte_pkg;

    // cordic iterations, capped at the length of the angle table
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int NSTEP        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    localparam int VW           = 36;   // vector component width, q.30 integers
    localparam int CW           = 48;   // cordic datapath width
    localparam int ZW           = 27;   // angle accumulator, degrees q.16
    localparam int AW           = ZW - 9; // rounded angle, degrees q.7

    localparam int SQRT_STEPS   = 31;
    localparam int FRONT_LAT    = 4 + SQRT_STEPS;
    localparam int NORM_STEPS   = 6;
    localparam int LANE_LAT     = 1 + NORM_STEPS + NSTEP + 1;
    localparam int BACK_LAT     = LANE_LAT + 1;
    localparam int FIFO_DEPTH   = 4;

    localparam logic signed [ZW-1:0] ANG90  = 27'sd5898240;
    localparam logic signed [ZW-1:0] ANG180 = 27'sd11796480;
    localparam logic signed [AW-1:0] LIM180 = 18'sd23040;
    localparam logic signed [AW-1:0] LIM90  = 18'sd11520;

    // round(atan(2^-i) in degrees * 65536)
    localparam logic [21:0] ATAN_TAB [TAB_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef struct packed {
        logic signed [VW-1:0] ry;
        logic signed [VW-1:0] rx;
        logic signed [VW-1:0] yy;
        logic signed [VW-1:0] yx;
        logic signed [VW-1:0] s;
    } prod_t;

    typedef struct packed {
        logic signed [VW-1:0] ry;
        logic signed [VW-1:0] rx;
        logic signed [VW-1:0] yy;
        logic signed [VW-1:0] yx;
        logic signed [VW-1:0] s;
        logic signed [VW-1:0] c;
    } vec_t;

endpackage

[design/quaternion_to_euler_angles_top.sv]
`timescale 1ns / 1ps
// channel  dir  ports                      word contents (lowest bit first)
// s_       in   s_tvalid s_tready s_tdata   quat_w[15:0] quat_x quat_y quat_z
// m_       out  m_tvalid m_tready m_tdata   roll_deg[15:0] pitch_deg[14:0] yaw_deg[15:0]
//
// one word per cycle in and out at full rate while neither side stalls; each word
// passes through the 31-step square root pipe, the queue and the three cordic
// lanes
// reset (aresetn low, synchronous) empties both pipes and the queue
// the front stalls only when the queue is full, the back only when m_tready is low
module quaternion_to_euler_angles_top import qte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll_deg, pitch_deg, yaw_deg, one zero pad bit
);

    // front to queue
    logic f_vld;
    logic q_full;
    vec_t f_data;

    // queue to back
    logic q_nempty;
    logic b_pop;
    vec_t q_data;

    // products, asin argument and its cosine
    qte_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (s_tvalid),
        .in_rdy   (s_tready),
        .in_data  (s_tdata),
        .out_vld  (f_vld),
        .out_rdy  (!q_full),
        .out_data (f_data)
    );

    // short queue decouples the two pipes
    qte_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_vld),
        .wr_data (f_data),
        .full    (q_full),
        .pop     (b_pop),
        .nempty  (q_nempty),
        .rd_data (q_data)
    );

    // three atan2 lanes and the output register
    qte_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (q_nempty),
        .in_pop   (b_pop),
        .in_data  (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[design/qte_front.sv]
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_vld,
    output logic        in_rdy,
    input  logic [63:0] in_data,
    output logic        out_vld,
    input  logic        out_rdy,
    output vec_t        out_data
);

    localparam logic signed [VW-1:0] ONE_Q30 = 36'sd1073741824;

    logic                 ce;
    logic [FRONT_LAT-1:0] vld_reg;
    logic [FRONT_LAT-1:0] vld_next;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] p01_reg, p23_reg, p11_reg, p22_reg, p03_reg;
    logic signed [31:0] p12_reg, p33_reg, p02_reg, p31_reg;

    prod_t              pr_reg [SQRT_STEPS+3];
    prod_t              pr2;
    logic signed [VW-1:0] s_raw, s_abs;
    logic [61:0]        sq_reg;
    logic [60:0]        sv_reg [SQRT_STEPS+1];
    logic [61:0]        sr_reg [SQRT_STEPS+1];

    assign ce      = !vld_reg[FRONT_LAT-1] || out_rdy;
    assign in_rdy  = ce;
    assign out_vld = vld_reg[FRONT_LAT-1];

    assign qw = in_data[15:0];
    assign qx = in_data[31:16];
    assign qy = in_data[47:32];
    assign qz = in_data[63:48];

    always_comb begin
        vld_next = {vld_reg[FRONT_LAT-2:0], in_vld};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (ce) begin
            p01_reg <= qw * qx;
            p23_reg <= qy * qz;
            p11_reg <= qx * qx;
            p22_reg <= qy * qy;
            p03_reg <= qw * qz;
            p12_reg <= qx * qy;
            p33_reg <= qz * qz;
            p02_reg <= qw * qy;
            p31_reg <= qz * qx;
        end
    end

    // stage 2: sums, asin argument clipped to +-1
    always_comb begin
        pr2.ry = (VW'(p01_reg) + VW'(p23_reg)) <<< 1;
        pr2.rx = ONE_Q30 - ((VW'(p11_reg) + VW'(p22_reg)) <<< 1);
        pr2.yy = (VW'(p03_reg) + VW'(p12_reg)) <<< 1;
        pr2.yx = ONE_Q30 - ((VW'(p22_reg) + VW'(p33_reg)) <<< 1);
        s_raw  = (VW'(p02_reg) - VW'(p31_reg)) <<< 1;
        if (s_raw > ONE_Q30) begin
            pr2.s = ONE_Q30;
        end else if (s_raw < -ONE_Q30) begin
            pr2.s = -ONE_Q30;
        end else begin
            pr2.s = s_raw;
        end
        s_abs = (pr_reg[0].s < 0) ? -pr_reg[0].s : pr_reg[0].s;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pr_reg[0] <= pr2;
            // stage 3: s squared
            pr_reg[1] <= pr_reg[0];
            sq_reg    <= s_abs[30:0] * s_abs[30:0];
            // stage 4: radicand 1 - s^2
            pr_reg[2] <= pr_reg[1];
            sv_reg[0] <= (61'(1) << 60) - sq_reg[60:0];
            sr_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [61:0] BITV = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [61:0] t;
        logic        take;
        assign t    = sr_reg[k] + BITV;
        assign take = {1'b0, sv_reg[k]} >= t;
        always_ff @(posedge aclk) begin
            if (ce) begin
                pr_reg[k+3] <= pr_reg[k+2];
                if (take) begin
                    sv_reg[k+1] <= sv_reg[k] - t[60:0];
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BITV;
                end else begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    always_comb begin
        out_data.ry = pr_reg[SQRT_STEPS+2].ry;
        out_data.rx = pr_reg[SQRT_STEPS+2].rx;
        out_data.yy = pr_reg[SQRT_STEPS+2].yy;
        out_data.yx = pr_reg[SQRT_STEPS+2].yx;
        out_data.s  = pr_reg[SQRT_STEPS+2].s;
        out_data.c  = VW'(sr_reg[SQRT_STEPS][30:0]);
    end

endmodule

[design/qte_fifo.sv]
`timescale 1ns / 1ps
module qte_fifo import qte_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  vec_t wr_data,
    output logic full,
    input  logic pop,
    output logic nempty,
    output vec_t rd_data
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    vec_t          mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = cnt_reg == NW'(FIFO_DEPTH);
    assign nempty  = cnt_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && nempty;
    assign rd_data = mem_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wp_reg <= (wp_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop) begin
                rp_reg <= (rp_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(FIFO_DEPTH)) else $error("fifo count past depth");

    a_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("fifo count missed a push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0 || cnt_reg == NW'(FIFO_DEPTH)) |-> wp_reg == rp_reg)
        else $error("fifo pointers out of step with count");

endmodule

[design/qte_atan2.sv]
`timescale 1ns / 1ps
module qte_atan2 import qte_pkg::*; (
    input  logic                 aclk,
    input  logic                 ce,
    input  logic signed [VW-1:0] y_i,
    input  logic signed [VW-1:0] x_i,
    output logic signed [AW-1:0] ang_o
);

    localparam int NS = NORM_STEPS + NSTEP + 1;

    logic signed [VW-1:0] xf, yf;
    logic signed [ZW-1:0] z0, zb;

    logic signed [CW-1:0] x_reg  [NS];
    logic signed [CW-1:0] y_reg  [NS];
    logic signed [ZW-1:0] z_reg  [NS];
    logic signed [ZW-1:0] zb_reg [NS];
    logic                 byp_reg [NS];
    logic signed [ZW-1:0] zf, zr;

    // left half plane folded over, axis and zero vectors bypass the iterations
    always_comb begin
        if (x_i < 0) begin
            xf = -x_i;
            yf = -y_i;
            z0 = (y_i >= 0) ? ANG180 : -ANG180;
        end else begin
            xf = x_i;
            yf = y_i;
            z0 = '0;
        end
        if (yf == 0) begin
            zb = z0;
        end else if (yf > 0) begin
            zb = z0 + ANG90;
        end else begin
            zb = z0 - ANG90;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]   <= CW'(xf);
            y_reg[0]   <= CW'(yf);
            z_reg[0]   <= z0;
            zb_reg[0]  <= zb;
            byp_reg[0] <= (yf == 0) || (xf == 0);
        end
    end

    // scale up until one component reaches 2^40
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic [CW-1:0]        ax, ay;
        logic                 fit;
        logic signed [CW-1:0] xs, ys;
        always_comb begin
            ax  = x_reg[j];
            ay  = (y_reg[j] < 0) ? -y_reg[j] : y_reg[j];
            fit = (ax < (CW'(1) << (40 - SH))) && (ay < (CW'(1) << (40 - SH)));
            xs  = fit ? (x_reg[j] <<< SH) : x_reg[j];
            ys  = fit ? (y_reg[j] <<< SH) : y_reg[j];
            if (j == NORM_STEPS - 1) begin
                xs = xs <<< 1;
                ys = ys <<< 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                x_reg[j+1]   <= xs;
                y_reg[j+1]   <= ys;
                z_reg[j+1]   <= z_reg[j];
                zb_reg[j+1]  <= zb_reg[j];
                byp_reg[j+1] <= byp_reg[j];
            end
        end
    end

    // vectoring iterations
    for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
        localparam int P = NORM_STEPS + i;
        logic signed [CW-1:0] xs, ys;
        logic signed [ZW-1:0] da;
        assign xs = x_reg[P] >>> i;
        assign ys = y_reg[P] >>> i;
        assign da = $signed(ZW'(ATAN_TAB[i]));
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (y_reg[P] > 0) begin
                    x_reg[P+1] <= x_reg[P] + ys;
                    y_reg[P+1] <= y_reg[P] - xs;
                    z_reg[P+1] <= z_reg[P] + da;
                end else begin
                    x_reg[P+1] <= x_reg[P] - ys;
                    y_reg[P+1] <= y_reg[P] + xs;
                    z_reg[P+1] <= z_reg[P] - da;
                end
                zb_reg[P+1]  <= zb_reg[P];
                byp_reg[P+1] <= byp_reg[P];
            end
        end
    end

    // round q.16 to q.7
    always_comb begin
        zf = byp_reg[NS-1] ? zb_reg[NS-1] : z_reg[NS-1];
        zr = zf + 27'sd256;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ang_o <= zr[ZW-1:9];
        end
    end

endmodule

[design/qte_back.sv]
`timescale 1ns / 1ps
module qte_back import qte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_vld,
    output logic        in_pop,
    input  vec_t        in_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    logic                 ce;
    logic [BACK_LAT-1:0]  vld_reg;
    logic signed [AW-1:0] roll_a, pitch_a, yaw_a;
    logic signed [AW-1:0] roll_c, pitch_c, yaw_c;
    logic [47:0]          data_reg;

    assign ce       = !vld_reg[BACK_LAT-1] || m_tready;
    assign in_pop   = in_vld && ce;
    assign m_tvalid = vld_reg[BACK_LAT-1];
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[BACK_LAT-2:0], in_vld};
        end
    end

    qte_atan2 u_roll (
        .aclk  (aclk),
        .ce    (ce),
        .y_i   (in_data.ry),
        .x_i   (in_data.rx),
        .ang_o (roll_a)
    );

    qte_atan2 u_pitch (
        .aclk  (aclk),
        .ce    (ce),
        .y_i   (in_data.s),
        .x_i   (in_data.c),
        .ang_o (pitch_a)
    );

    qte_atan2 u_yaw (
        .aclk  (aclk),
        .ce    (ce),
        .y_i   (in_data.yy),
        .x_i   (in_data.yx),
        .ang_o (yaw_a)
    );

    always_comb begin
        roll_c  = (roll_a > LIM180) ? LIM180 : ((roll_a < -LIM180) ? -LIM180 : roll_a);
        pitch_c = (pitch_a > LIM90) ? LIM90 : ((pitch_a < -LIM90) ? -LIM90 : pitch_a);
        yaw_c   = (yaw_a > LIM180) ? LIM180 : ((yaw_a < -LIM180) ? -LIM180 : yaw_a);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            data_reg <= {1'b0, yaw_c[15:0], pitch_c[14:0], roll_c[15:0]};
        end
    end

endmodule

[tb/quaternion_to_euler_angles_top_tb.sv]
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top_tb;
    import qte_pkg::*;

    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint NORM_LIM   = 64'sd1099511627776;
    localparam longint DEG90_Q16  = 64'sd5898240;
    localparam longint DEG180_Q16 = 64'sd11796480;
    localparam int     N_RANDOM   = 600;
    localparam int     WATCHDOG   = 5000;
    localparam int     DRAIN      = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // quat_w, quat_x, quat_y, quat_z
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // roll_deg, pitch_deg, yaw_deg, pad

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } euler_t;

    // isqrt by digit-by-digit method
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in degrees q.16
    function automatic longint atan2_deg(longint y, longint x);
        longint z, xs, ys, ay;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? DEG180_Q16 : -DEG180_Q16;
            x = -x;
            y = -y;
        end
        if (y == 0) return z;
        if (x == 0) return z + ((y > 0) ? DEG90_Q16 : -DEG90_Q16);
        ay = (y < 0) ? -y : y;
        while (x < NORM_LIM && ay < NORM_LIM) begin
            x = x * 2;
            y = y * 2;
            ay = ay * 2;
        end
        for (int i = 0; i < NSTEP; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint round_deg(longint z, longint lim);
        longint d;
        d = (z + 256) >>> 9;
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return d;
    endfunction

    function automatic euler_t quat_to_euler(logic [63:0] word);
        longint q0, q1, q2, q3, s, c;
        euler_t e;
        q0 = longint'($signed(word[15:0]));
        q1 = longint'($signed(word[31:16]));
        q2 = longint'($signed(word[47:32]));
        q3 = longint'($signed(word[63:48]));
        s = 2 * (q0 * q2 - q3 * q1);
        if (s > ONE_Q30) s = ONE_Q30;
        if (s < -ONE_Q30) s = -ONE_Q30;
        c = longint'(isqrt(longint'(ONE_Q30 * ONE_Q30) - s * s));
        e.roll  = 16'(round_deg(atan2_deg(2 * (q0 * q1 + q2 * q3),
                                          ONE_Q30 - 2 * (q1 * q1 + q2 * q2)), 23040));
        e.pitch = 15'(round_deg(atan2_deg(s, c), 11520));
        e.yaw   = 16'(round_deg(atan2_deg(2 * (q0 * q3 + q1 * q2),
                                          ONE_Q30 - 2 * (q2 * q2 + q3 * q3)), 23040));
        return e;
    endfunction

    class angle_scoreboard;
        euler_t expected_angles[$];
        logic [63:0] sent_quats[$];
        int errors;
        int n_in;

        function void note_quat(logic [63:0] word);
            expected_angles.push_back(quat_to_euler(word));
            sent_quats.push_back(word);
            n_in++;
        endfunction

        task report(string line);
            $display("%s", line);
            errors++;
        endtask

        task check_angles(logic [47:0] word);
            euler_t want;
            logic [63:0] q;
            if (expected_angles.size() == 0) begin
                report($sformatf("mismatch: result word %h with nothing outstanding", word));
                return;
            end
            want = expected_angles.pop_front();
            q = sent_quats.pop_front();
            if ($signed(word[15:0]) != want.roll)
                report($sformatf("mismatch roll quat=%h got=%0d expected=%0d",
                                 q, $signed(word[15:0]), want.roll));
            if ($signed(word[30:16]) != want.pitch)
                report($sformatf("mismatch pitch quat=%h got=%0d expected=%0d",
                                 q, $signed(word[30:16]), want.pitch));
            if ($signed(word[46:31]) != want.yaw)
                report($sformatf("mismatch yaw quat=%h got=%0d expected=%0d",
                                 q, $signed(word[46:31]), want.yaw));
        endtask
    endclass

    angle_scoreboard sb;
    bit late_phase;
    int quiet_cycles;

    quaternion_to_euler_angles_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // accepted words on both sides, plus the watchdog
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && s_tready) sb.note_quat(s_tdata);
            if (m_tvalid && m_tready) sb.check_angles(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (sb.expected_angles.size() == 0 && !s_tvalid))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG) begin
                $display("quaternion_to_euler_angles_top_tb: errors");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!late_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // random unit quaternion, sometimes pushed toward gimbal lock
    task automatic send_unit_quat();
        real c[4];
        real n;
        n = 0.0;
        while (n < 100.0) begin
            for (int k = 0; k < 4; k++) c[k] = real'(int'($urandom_range(0, 65535)) - 32768);
            if ($urandom_range(0, 5) == 0) begin
                c[0] = 23170.0 + c[0] / 64.0;
                c[2] = (($urandom_range(0, 1) != 0) ? 23170.0 : -23170.0) + c[2] / 64.0;
                c[1] = c[1] / 64.0;
                c[3] = c[3] / 64.0;
            end
            n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        end
        send_quat(16'($rtoi(c[0] * 32767.0 / n)), 16'($rtoi(c[1] * 32767.0 / n)),
                  16'($rtoi(c[2] * 32767.0 / n)), 16'($rtoi(c[3] * 32767.0 / n)));
    endtask

    // result side: random back-pressure and one long hold-off
    initial begin
        bit held;
        held = 0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!held && sb.n_in >= 120) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (!late_phase && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin
        sb = new();
        late_phase = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, extremes, axes, zero vectors, gimbal lock
        send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
        send_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sd23170, -16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0);
        send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0);
        send_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170);
        send_quat(16'sd23170, 16'sd0, 16'sd0, -16'sd23170);
        send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
        send_quat(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd32767);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(16'sd100, -16'sd3, 16'sd7, -16'sd1);
        send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 100) late_phase = 1;
            // one pause until everything in flight has come back
            if (n == 300) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (sb.expected_angles.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 3) == 0)
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_unit_quat();
        end
        s_tvalid <= 1'b0;

        while (sb.expected_angles.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (sb.errors == 0)
            $display("quaternion_to_euler_angles_top_tb: clean");
        else
            $display("quaternion_to_euler_angles_top_tb: errors");
        $finish;
    end

endmodule
